// File: rtl/bis_pkg.sv
// Shared types, constants and register indexes of the block importance scorer.
package bis_pkg;

    // Field widths.
    localparam int VAL_W    = 16;
    localparam int TERM_W   = 31;
    localparam int SUM_W    = 43;
    localparam int BS_W     = 13;
    localparam int BLK_W    = 20;
    localparam int SCORE_W  = 31;
    localparam int CNT_W    = 17;

    // Default block size clamp.
    localparam int MAX_BLOCK_DEF = 4096;

    // 1.0 in Q1.15.
    localparam logic [VAL_W-1:0] ONE_Q15 = 16'h8000;

    // Square root unit: the mean is padded to an even width.
    localparam int SQ_IN_W   = SUM_W + 1;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int SQ_REM_W  = ROOT_W + 2;
    localparam int DIV_STEPS = SUM_W;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int STEP_W    = 6;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ACT    = 2'd2;

    localparam logic [BS_W-1:0] BLK_LEN_RST = 13'd256;

    // Score modes.
    localparam logic MODE_MEAN   = 1'b0;
    localparam logic MODE_FISHER = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] weight;
        logic signed [VAL_W-1:0] companion;
        logic                    tensor_end;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [BLK_W-1:0]   block_number;
        logic               final_block;
    } t_out_item;

    typedef struct packed {
        logic [BS_W-1:0] blk_len;
        logic            score_mode;
        logic            use_activations;
    } t_cfg;

    // One closed block waiting for its score.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             mode;
        logic [VAL_W-1:0] lead_mag;
        logic [BLK_W-1:0] block_number;
        logic             final_block;
    } t_job;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SQRT,
        B_FIN
    } t_bstate;

    // Magnitude of a Q1.15 value; the most negative value maps to 1.0.
    function automatic logic [VAL_W-1:0] mag16(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] m;
        m = v[VAL_W-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

endpackage

// File: rtl/bis_fifo.sv
// Short job queue between the accumulating front and the scoring back.
module bis_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  bis_pkg::t_job          i_push_data,
    input  logic                   i_pop,
    output bis_pkg::t_job          o_head,
    output logic                   o_empty,
    output logic [bis_pkg::FIFO_CW-1:0] o_count
);
    import bis_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// File: rtl/bis_front.sv
// Front part: takes items, forms per-item terms and closes blocks into jobs.
module bis_front #(
    parameter int MAX_BLOCK = bis_pkg::MAX_BLOCK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bis_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bis_pkg::t_in_item           i_in_data,
    input  logic [bis_pkg::FIFO_CW-1:0] i_fifo_count,
    output logic                        o_push,
    output bis_pkg::t_job               o_job
);
    import bis_pkg::*;

    localparam int CW = $clog2(MAX_BLOCK + 1);

    // Term stage.
    logic              r_a_valid;
    logic [TERM_W-1:0] r_a_term;
    logic [VAL_W-1:0]  r_a_wmag;
    logic              r_a_last;

    // Block accumulation state.
    logic [SUM_W-1:0]  r_sum;
    logic [CW-1:0]     r_cnt;
    logic [BLK_W-1:0]  r_blk;
    logic [VAL_W-1:0]  r_lead;

    logic [SUM_W-1:0]  n_sum;
    logic [CW-1:0]     n_cnt;
    logic [BLK_W-1:0]  n_blk;
    logic [VAL_W-1:0]  n_lead;

    logic              accept;
    logic [VAL_W-1:0]  wmag;
    logic [VAL_W-1:0]  cmag;
    logic [VAL_W-1:0]  op_a;
    logic [VAL_W-1:0]  op_b;
    logic [2*VAL_W-1:0] prod;
    logic [CW-1:0]     limit;
    logic [CW:0]       cnt_inc;
    logic [SUM_W-1:0]  sum_inc;
    logic [VAL_W-1:0]  lead_now;
    logic              close;

    // Room for the item in the term stage and the new one must be left.
    assign o_in_stall = ((FIFO_CW+1)'(i_fifo_count) + (FIFO_CW+1)'(r_a_valid))
                        >= (FIFO_CW+1)'(FIFO_DEPTH);
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        wmag = mag16(i_in_data.weight);
        cmag = mag16(i_in_data.companion);
        if (i_cfg.score_mode == MODE_FISHER) begin
            op_a = cmag;
            op_b = cmag;
        end else begin
            op_a = wmag;
            op_b = i_cfg.use_activations ? cmag : ONE_Q15;
        end
        prod = (2*VAL_W)'(op_a) * (2*VAL_W)'(op_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_term <= prod[TERM_W-1:0];
            r_a_wmag <= wmag;
            r_a_last <= i_in_data.tensor_end;
        end
    end

    // A zero size acts as one and an oversized one is clamped.
    always_comb begin
        if (i_cfg.blk_len == '0) begin
            limit = CW'(1);
        end else if (32'(i_cfg.blk_len) > 32'(MAX_BLOCK)) begin
            limit = CW'(MAX_BLOCK);
        end else begin
            limit = CW'(i_cfg.blk_len);
        end
    end

    always_comb begin
        sum_inc  = r_sum + SUM_W'(r_a_term);
        cnt_inc  = {1'b0, r_cnt} + (CW+1)'(1);
        lead_now = (r_cnt == '0) ? r_a_wmag : r_lead;
        close    = r_a_valid && ((cnt_inc >= {1'b0, limit}) || r_a_last);

        n_sum  = r_sum;
        n_cnt  = r_cnt;
        n_blk  = r_blk;
        n_lead = r_lead;
        if (r_a_valid) begin
            n_lead = lead_now;
            if (close) begin
                n_sum = '0;
                n_cnt = '0;
                n_blk = r_a_last ? '0 : r_blk + 1'b1;
            end else begin
                n_sum = sum_inc;
                n_cnt = cnt_inc[CW-1:0];
            end
        end

        o_push             = close;
        o_job.sum          = sum_inc;
        o_job.count        = CNT_W'(cnt_inc);
        o_job.mode         = i_cfg.score_mode;
        o_job.lead_mag     = lead_now;
        o_job.block_number = r_blk;
        o_job.final_block  = r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_blk  <= '0;
            r_lead <= '0;
        end else begin
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_blk  <= n_blk;
            r_lead <= n_lead;
        end
    end

endmodule

// File: rtl/bis_back.sv
// Back part: divides each job's sum by its count, in Fisher mode takes the root, and drives results.
module bis_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bis_pkg::t_job     i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bis_pkg::t_out_item o_out_data
);
    import bis_pkg::*;

    t_bstate r_state;
    t_bstate n_state;

    logic [SQ_IN_W-1:0]  r_quo;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_div;
    logic [ROOT_W-1:0]   r_root;
    logic [SQ_REM_W-1:0] r_sq_rem;
    logic [STEP_W-1:0]   r_step;
    logic                r_mode;
    logic [VAL_W-1:0]    r_lead;
    logic [BLK_W-1:0]    r_blk;
    logic                r_last;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [SQ_IN_W-1:0]  n_quo;
    logic [CNT_W-1:0]    n_rem;
    logic [ROOT_W-1:0]   n_root;
    logic [SQ_REM_W-1:0] n_sq_rem;
    logic [STEP_W-1:0]   n_step;
    logic                n_out_valid;
    logic                load;
    logic                out_free;

    logic [CNT_W:0]      div_t;
    logic                div_bit;
    logic [SQ_REM_W+1:0] sq_t;
    logic [SQ_REM_W+1:0] sq_trial;
    logic                sq_ok;
    logic [ROOT_W+VAL_W-1:0] fisher;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        div_t    = {r_rem, r_quo[SUM_W-1]};
        div_bit  = div_t >= {1'b0, r_div};
        sq_t     = {r_sq_rem, r_quo[SQ_IN_W-1 -: 2]};
        sq_trial = (SQ_REM_W+2)'({r_root, 2'b01});
        sq_ok    = sq_t >= sq_trial;
        fisher   = (ROOT_W+VAL_W)'(r_root) * (ROOT_W+VAL_W)'(r_lead);

        n_state  = r_state;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_root   = r_root;
        n_sq_rem = r_sq_rem;
        n_step   = r_step;
        o_pop    = 1'b0;
        load     = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_quo   = SQ_IN_W'(i_head.sum);
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                // One restoring step per cycle; quotient bits shift in from the right.
                n_rem  = div_bit ? CNT_W'(div_t - {1'b0, r_div}) : div_t[CNT_W-1:0];
                n_quo  = {1'b0, r_quo[SUM_W-2:0], div_bit};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step   = '0;
                    n_root   = '0;
                    n_sq_rem = '0;
                    n_state  = (r_mode == MODE_FISHER) ? B_SQRT : B_FIN;
                end
            end
            B_SQRT: begin
                // Digit-by-digit floor root, two radicand bits per cycle.
                n_sq_rem = sq_ok ? SQ_REM_W'(sq_t - sq_trial) : SQ_REM_W'(sq_t);
                n_root   = {r_root[ROOT_W-2:0], sq_ok};
                n_quo    = {r_quo[SQ_IN_W-3:0], 2'b00};
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(SQ_STEPS - 1)) begin
                    n_state = B_FIN;
                end
            end
            B_FIN: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_sq_rem <= n_sq_rem;
        r_step   <= n_step;
        if (o_pop) begin
            r_div  <= i_head.count;
            r_mode <= i_head.mode;
            r_lead <= i_head.lead_mag;
            r_blk  <= i_head.block_number;
            r_last <= i_head.final_block;
        end
        if (load) begin
            r_out.score        <= (r_mode == MODE_FISHER) ? fisher[SCORE_W-1:0]
                                                          : r_quo[SCORE_W-1:0];
            r_out.block_number <= r_blk;
            r_out.final_block  <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/block_importance_scorer.sv
// Top level of the block importance scorer: configuration registers, front, queue and back.
// A block is pushed into the job queue in the cycle after its last item is accepted; its score
// then passes the serial divider and, in Fisher mode, the root unit before it reaches the output.
// The front takes one item per cycle while the queue has room; the back scores one job at a time.
// Reset (synchronous, active low) loads a block length of 256, mean mode and activations on,
// and clears the block accumulators, the queue and the output valid flag.
module block_importance_scorer #(
    parameter int MAX_BLOCK = bis_pkg::MAX_BLOCK_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bis_pkg::t_in_item             i_in_data,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bis_pkg::t_out_item            o_out_data,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bis_pkg::BS_W-1:0]      i_cfg_data
);
    import bis_pkg::*;

    t_cfg               r_cfg;
    t_job               push_job;
    t_job               head_job;
    logic               push;
    logic               pop;
    logic               empty;
    logic [FIFO_CW-1:0] fifo_count;

    // The configuration registers take a write transaction in every cycle.
    // Writes are only expected while the block is idle, so no item ever sees
    // a register change halfway through its own processing.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blk_len         <= BLK_LEN_RST;
            r_cfg.score_mode      <= MODE_MEAN;
            r_cfg.use_activations <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLK_LEN:    r_cfg.blk_len         <= i_cfg_data;
                CFG_SCORE_MODE: r_cfg.score_mode      <= i_cfg_data[0];
                CFG_USE_ACT:    r_cfg.use_activations <= i_cfg_data[0];
                default: begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    // The front accepts one item per cycle while it is not stalled, forms its product term and
    // accumulates the block. When a block closes, its sum, count, lead weight
    // magnitude and number go into the queue as one job.
    bis_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_fifo_count (fifo_count),
        .o_push       (push),
        .o_job        (push_job)
    );

    // The queue lets the front keep streaming items while the back is busy
    // with an earlier block's division and root.
    bis_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_job),
        .i_pop       (pop),
        .o_head      (head_job),
        .o_empty     (empty),
        .o_count     (fifo_count)
    );

    // The back turns each job into one result transaction, held in an output
    // register until the receiver takes it.
    bis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
